>>> design/first_fit_heap_allocator_defines.svh
// Assertion macros for the allocator; empty when synthesizing.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define FFHA_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);
`else
`define FFHA_ASSERT(lbl, ck, rs, prop, msg)
`define FFHA_NEVER(lbl, ck, rs, expr, msg)
`endif

`endif

>>> design/ffha_pkg.sv
package ffha_pkg;

  localparam int FREE_ENTRIES_DEF = 64;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 24;
  localparam int SZ_W   = 25;  // rounded request, can reach 2^24
  localparam int LIM_W  = 29;

  localparam logic [ADDR_W-1:0] RESET_HEAP_BASE = 32'hE000_0000;
  localparam logic [LIM_W-1:0]  RESET_INITIAL   = 29'h010_0000;
  localparam logic [LIM_W-1:0]  RESET_MAX       = 29'h100_0000;

  localparam logic [SZ_W-1:0] ROUND_ADD  = 25'd7;
  localparam logic [SZ_W-1:0] ROUND_MASK = ~25'd7;

  localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [1:0] CFG_INITIAL   = 2'd1;
  localparam logic [1:0] CFG_MAX       = 2'd2;

  localparam logic [2:0] STATUS_OK   = 3'd0;
  localparam logic [2:0] STATUS_ZERO = 3'd1;
  localparam logic [2:0] STATUS_OOM  = 3'd2;
  localparam logic [2:0] STATUS_FULL = 3'd3;
  localparam logic [2:0] STATUS_NULL = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIT,
    ST_GROW,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic fit_en;
    logic grow_en;
    logic push;
    logic remove;
  } cell_ctrl_t;

endpackage

>>> design/ffha_cell.sv
module ffha_cell import ffha_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  input  logic [SZ_W-1:0]   sz,
  input  logic [ADDR_W-1:0] newer_addr,
  input  logic [SIZE_W-1:0] newer_size,
  input  logic [ADDR_W-1:0] older_addr,
  input  logic [SIZE_W-1:0] older_size,
  input  logic              seen_in,
  input  logic [ADDR_W-1:0] sel_in,
  output logic [ADDR_W-1:0] addr,
  output logic [SIZE_W-1:0] size,
  output logic              seen_out,
  output logic [ADDR_W-1:0] sel_out
);

  logic fit;
  logic take;
  logic shift;
  logic occupied;

  assign occupied = count > CW'(IDX);
  assign seen_out = seen_in | fit;
  assign sel_out  = sel_in | ({ADDR_W{take}} & addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      fit   <= 1'b0;
      take  <= 1'b0;
      shift <= 1'b0;
    end else begin
      if (ctrl.fit_en) begin
        fit <= occupied && ({1'b0, size} >= sz);
      end
      // first fit from the newest end: only the first hit takes, all after it close up
      if (ctrl.grow_en) begin
        take  <= fit & ~seen_in;
        shift <= seen_in | fit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      addr <= newer_addr;
      size <= newer_size;
    end else if (ctrl.remove && shift) begin
      addr <= older_addr;
      size <= older_size;
    end
  end

endmodule

>>> design/ffha_bump.sv
module ffha_bump import ffha_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              stage1_en,
  input  logic              stage2_en,
  input  logic [ADDR_W-1:0] bump_ptr,
  input  logic [ADDR_W-1:0] limit,
  input  logic [SZ_W-1:0]   sz,
  input  logic [ADDR_W-1:0] heap_base,
  input  logic [LIM_W-1:0]  max_bytes,
  output logic              fail,
  output logic [ADDR_W-1:0] end_addr,
  output logic [ADDR_W-1:0] new_limit
);

  localparam int PW = $clog2(PAGE_BYTES);

  logic [ADDR_W:0]   end_q;
  logic [ADDR_W:0]   ceil_q;
  logic              over_q;
  logic [ADDR_W+1:0] d_q;
  logic [ADDR_W+1:0] round_d;
  logic [ADDR_W+2:0] grown;

  always_ff @(posedge clk) begin
    if (stage1_en) begin
      end_q  <= {1'b0, bump_ptr} + (ADDR_W+1)'(sz) + (ADDR_W+1)'(HEADER_BYTES);
      ceil_q <= {1'b0, heap_base} + (ADDR_W+1)'(max_bytes);
    end
    if (stage2_en) begin
      over_q <= end_q > {1'b0, limit};
      d_q    <= (ADDR_W+2)'(end_q) - (ADDR_W+2)'(limit) + (ADDR_W+2)'(PAGE_BYTES - 1);
    end
  end

  // whole pages above the current limit
  assign round_d   = {d_q[ADDR_W+1:PW], PW'(0)};
  assign grown     = (ADDR_W+3)'(limit) + (ADDR_W+3)'(round_d);
  assign new_limit = over_q ? grown[ADDR_W-1:0] : limit;
  assign end_addr  = end_q[ADDR_W-1:0];
  assign fail      = end_q[ADDR_W]
                   | (over_q & ((grown > (ADDR_W+3)'(ceil_q)) | (grown[ADDR_W+2:ADDR_W] != 3'b0)));

endmodule

>>> design/first_fit_heap_allocator.sv
// First-fit heap allocator. One request is in flight at a time. An allocate
// of nonzero size passes from IDLE through the FIT and GROW states to
// COMMIT (compare in every free-list cell, priority pick along the cell
// chain together with the page-growth arithmetic, then commit); a free or a
// zero-size allocate goes straight from IDLE to COMMIT, and either one then
// leaves its result in the result register at commit and returns to IDLE. The
// next request is taken as soon as the current one has committed into the
// result register, even while that result still waits for out_ready. A
// result held back by out_ready stalls the commit of the following request.
// The free list lives in a chain of FREE_ENTRIES cells, the newest entry in
// cell 0; a free shifts every cell one place down and a hit closes the gap by
// shifting the older cells up. Configuration is taken in any cycle; bump
// pointer and mapped limit reset to package constants, not to the configured
// values. Entries are not cleared at reset, so no clearing pass is needed.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [ADDR_W-1:0] free_addr,
  input  logic [SIZE_W-1:0] freed_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] result_addr,
  output logic [2:0]        status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int CW = $clog2(FREE_ENTRIES + 1);

  state_t state, state_next;

  logic [ADDR_W-1:0] heap_base;
  logic [LIM_W-1:0]  initial_bytes;
  logic [LIM_W-1:0]  max_heap_bytes;
  logic [CW-1:0]     free_count;
  logic [ADDR_W-1:0] bump_pointer;
  logic [ADDR_W-1:0] mapped_limit;

  logic              act_q;
  logic              zero_q;
  logic [SZ_W-1:0]   sz_q;
  logic [ADDR_W-1:0] faddr_q;
  logic [SIZE_W-1:0] fsize_q;
  logic              hit_any;

  logic       accept;
  logic       commit;
  cell_ctrl_t ctrl;

  logic              do_push;
  logic              do_remove;
  logic              do_bump;
  logic [ADDR_W-1:0] res_addr;
  logic [2:0]        res_status;

  logic              grow_fail;
  logic [ADDR_W-1:0] grow_end;
  logic [ADDR_W-1:0] grow_limit;

  logic [ADDR_W-1:0] ent_addr [FREE_ENTRIES];
  logic [SIZE_W-1:0] ent_size [FREE_ENTRIES];
  logic              seen     [FREE_ENTRIES+1];
  logic [ADDR_W-1:0] sel      [FREE_ENTRIES+1];
  logic [ADDR_W-1:0] push_addr;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign push_addr = faddr_q - ADDR_W'(HEADER_BYTES);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base      <= RESET_HEAP_BASE;
      initial_bytes  <= RESET_INITIAL;
      max_heap_bytes <= RESET_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEAP_BASE: heap_base      <= cfg_data;
        CFG_INITIAL:   initial_bytes  <= cfg_data[LIM_W-1:0];
        CFG_MAX:       max_heap_bytes <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (!action && req_size != '0) ? ST_FIT : ST_COMMIT;
        end
      end
      ST_FIT:    state_next = ST_GROW;
      ST_GROW:   state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready     = 1'b0;
    commit       = 1'b0;
    ctrl.fit_en  = 1'b0;
    ctrl.grow_en = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_FIT:    ctrl.fit_en = 1'b1;
      ST_GROW:   ctrl.grow_en = 1'b1;
      ST_COMMIT: commit = !out_valid || out_ready;
      default: ;
    endcase
    ctrl.push   = commit && do_push;
    ctrl.remove = commit && do_remove;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q   <= action;
      zero_q  <= req_size == '0;
      sz_q    <= ({1'b0, req_size} + ROUND_ADD) & ROUND_MASK;
      faddr_q <= free_addr;
      fsize_q <= freed_size;
    end
    if (ctrl.grow_en) begin
      hit_any <= seen[FREE_ENTRIES];
    end
  end

  // outcome of the held request
  always_comb begin
    do_push    = 1'b0;
    do_remove  = 1'b0;
    do_bump    = 1'b0;
    res_addr   = '0;
    res_status = STATUS_OK;
    if (act_q) begin
      if (faddr_q == '0) begin
        res_status = STATUS_NULL;
      end else if (free_count == CW'(FREE_ENTRIES)) begin
        res_status = STATUS_FULL;
      end else begin
        do_push = 1'b1;
      end
    end else if (zero_q) begin
      res_status = STATUS_ZERO;
    end else if (hit_any) begin
      do_remove = 1'b1;
      res_addr  = sel[FREE_ENTRIES] + ADDR_W'(HEADER_BYTES);
    end else if (grow_fail) begin
      res_status = STATUS_OOM;
    end else begin
      do_bump  = 1'b1;
      res_addr = bump_pointer + ADDR_W'(HEADER_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= '0;
      bump_pointer <= RESET_HEAP_BASE;
      mapped_limit <= RESET_HEAP_BASE + ADDR_W'(RESET_INITIAL);
    end else if (commit) begin
      if (do_push) begin
        free_count <= free_count + 1'b1;
      end else if (do_remove) begin
        free_count <= free_count - 1'b1;
      end
      if (do_bump) begin
        bump_pointer <= grow_end;
        mapped_limit <= grow_limit;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result_addr <= res_addr;
      status      <= res_status;
    end
  end

  ffha_bump #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_bump (
    .clk      (clk),
    .stage1_en(ctrl.fit_en),
    .stage2_en(ctrl.grow_en),
    .bump_ptr (bump_pointer),
    .limit    (mapped_limit),
    .sz       (sz_q),
    .heap_base(heap_base),
    .max_bytes(max_heap_bytes),
    .fail     (grow_fail),
    .end_addr (grow_end),
    .new_limit(grow_limit)
  );

  assign seen[0] = 1'b0;
  assign sel[0]  = '0;

  for (genvar k = 0; k < FREE_ENTRIES; k++) begin : g_cell
    logic [ADDR_W-1:0] newer_addr;
    logic [SIZE_W-1:0] newer_size;
    logic [ADDR_W-1:0] older_addr;
    logic [SIZE_W-1:0] older_size;

    if (k == 0) begin : g_front
      assign newer_addr = push_addr;
      assign newer_size = fsize_q;
    end else begin : g_mid
      assign newer_addr = ent_addr[k-1];
      assign newer_size = ent_size[k-1];
    end

    if (k == FREE_ENTRIES - 1) begin : g_back
      assign older_addr = '0;
      assign older_size = '0;
    end else begin : g_rest
      assign older_addr = ent_addr[k+1];
      assign older_size = ent_size[k+1];
    end

    ffha_cell #(
      .IDX(k),
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (free_count),
      .sz        (sz_q),
      .newer_addr(newer_addr),
      .newer_size(newer_size),
      .older_addr(older_addr),
      .older_size(older_size),
      .seen_in   (seen[k]),
      .sel_in    (sel[k]),
      .addr      (ent_addr[k]),
      .size      (ent_size[k]),
      .seen_out  (seen[k+1]),
      .sel_out   (sel[k+1])
    );
  end

  `FFHA_NEVER(a_count_range, clk, rst, free_count > CW'(FREE_ENTRIES), "free count past capacity")
  `FFHA_ASSERT(a_remove_nonempty, clk, rst, ctrl.remove |-> free_count != '0, "hit on empty free list")
  `FFHA_ASSERT(a_fail_null, clk, rst, (out_valid && status != STATUS_OK) |-> result_addr == '0, "nonzero address on failure")
  `FFHA_ASSERT(a_commit_shows, clk, rst, commit |=> out_valid, "committed result not presented")

endmodule
